// ===== src/ray_disc_intersection_defines.svh =====
`ifndef RAY_DISC_INTERSECTION_DEFINES_SVH
`define RAY_DISC_INTERSECTION_DEFINES_SVH

// Assertion helpers. Both sample on the rising clock edge and are disabled
// while the active-low reset is asserted.
`ifndef ASSERT_OFF
`define RDI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RDI_ASSERT(lbl, clk, rstn, prop, msg)
`define RDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/rdi_pkg.sv =====
package rdi_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS_SQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS_SQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_EPSILON = 3'd4;

  // Number of quotient bits kept by the divider; larger depths saturate.
  localparam int QUOT_W = 31;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] depth;
  } ray_out_t;

  typedef struct packed {
    logic [31:0] inner_radius_sq;
    logic [31:0] outer_radius_sq;
    logic [30:0] min_depth;
    logic [30:0] max_depth;
    logic [15:0] parallel_epsilon;
  } cfg_t;

  // Ray data that rides alongside the arithmetic through the pipeline.
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic               miss;
  } side_t;

endpackage

// ===== src/ray_disc_intersection.sv =====
// Ray against annulus test in the z = 0 plane of the disc frame. One ray
// transaction is taken in every clock cycle (busy never rises), and its
// result appears on out_result with out_valid high for exactly one cycle
// and in order. The pipeline is built around the depth division, which
// registers its operands once and then produces one quotient bit per
// stage over 31 stages, plus four stages of length and parallel tests
// ahead of it and five stages of hit point and window tests behind it.
// The receiver cannot stall the pipeline, so every result must be taken
// in the cycle it is shown.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data; write them only while no ray is in flight.
`include "ray_disc_intersection_defines.svh"

module ray_disc_intersection #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rdi_pkg::ray_in_t                    in_ray,
  output logic                                out_valid,
  output rdi_pkg::ray_out_t                   out_result,
  input  logic                                cfg_we,
  input  logic [rdi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Registers from input to output: front end, divider, back end.
  localparam int PIPE_DEPTH = 4 + (rdi_pkg::QUOT_W + 1) + 5;
  localparam int DVD_W      = 32 + COORD_FRAC_BITS;

  rdi_pkg::cfg_t cfg_r, cfg_nxt;

  logic                    in_accept;
  logic                    fe_valid, dv_valid;
  rdi_pkg::side_t          fe_side, dv_side;
  logic [DVD_W-1:0]        fe_dividend;
  logic [31:0]             fe_divisor;
  logic [rdi_pkg::QUOT_W-1:0] dv_quot;

  // The pipeline never holds off a ray.
  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  // Writes to indexes beyond the register list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rdi_pkg::CFG_INNER_RADIUS_SQ:  cfg_nxt.inner_radius_sq  = cfg_data;
        rdi_pkg::CFG_OUTER_RADIUS_SQ:  cfg_nxt.outer_radius_sq  = cfg_data;
        rdi_pkg::CFG_MIN_DEPTH:        cfg_nxt.min_depth        = cfg_data[30:0];
        rdi_pkg::CFG_MAX_DEPTH:        cfg_nxt.max_depth        = cfg_data[30:0];
        rdi_pkg::CFG_PARALLEL_EPSILON: cfg_nxt.parallel_epsilon = cfg_data[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inner_radius_sq  <= 32'd0;
      cfg_r.outer_radius_sq  <= 32'd65536;
      cfg_r.min_depth        <= 31'd1;
      cfg_r.max_depth        <= 31'h7FFF_FFFF;
      cfg_r.parallel_epsilon <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Magnitudes, squared direction length and the parallel rejection.
  rdi_front #(.FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_accept),
    .in_ray       (in_ray),
    .eps          (cfg_r.parallel_epsilon),
    .out_valid    (fe_valid),
    .out_side     (fe_side),
    .out_dividend (fe_dividend),
    .out_divisor  (fe_divisor)
  );

  // Depth = (|Pz| << F) / |Dz|, saturated to the 31-bit field.
  rdi_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (fe_valid),
    .in_side     (fe_side),
    .in_dividend (fe_dividend),
    .in_divisor  (fe_divisor),
    .out_valid   (dv_valid),
    .out_side    (dv_side),
    .out_quot    (dv_quot)
  );

  // Hit point, radius window and depth window, then the output register.
  rdi_hitpt #(.FRAC_BITS(COORD_FRAC_BITS)) u_hitpt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_side    (dv_side),
    .in_quot    (dv_quot),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // Every accepted ray comes out after the fixed latency, and nothing else does.
  `RDI_ASSERT(a_latency, clk, rst_n, in_accept |-> ##PIPE_DEPTH out_valid, "result lost")
  `RDI_ASSERT(a_no_ghost, clk, rst_n, !in_accept |-> ##PIPE_DEPTH !out_valid, "extra result")
  // A miss reports depth zero, and a hit reports a nonzero depth (it lies beyond the minimum depth).
  `RDI_ASSERT(a_miss_depth, clk, rst_n,
    (out_valid && !out_result.hit) |-> (out_result.depth == 31'd0), "miss with depth")
  `RDI_ASSERT(a_hit_depth, clk, rst_n,
    (out_valid && out_result.hit) |-> (out_result.depth != 31'd0), "hit at zero depth")

endmodule

// ===== src/rdi_front.sv =====
// Magnitudes, squared lengths and the exact parallel test.
module rdi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  rdi_pkg::ray_in_t        in_ray,
  input  logic [15:0]             eps,
  output logic                    out_valid,
  output rdi_pkg::side_t          out_side,
  output logic [32+FRAC_BITS-1:0] out_dividend,
  output logic [31:0]             out_divisor
);

  localparam int DVD_W = 32 + FRAC_BITS;

  // Stage 1: magnitudes and sign checks.
  logic                 v1_r, v1_nxt;
  rdi_pkg::side_t       s1_r, s1_nxt;
  logic [31:0]          adx1_r, adx1_nxt, ady1_r, ady1_nxt, adz1_r, adz1_nxt;
  logic [DVD_W-1:0]     dvd1_r, dvd1_nxt;
  // Stage 2: squares.
  logic                 v2_r, v2_nxt;
  rdi_pkg::side_t       s2_r, s2_nxt;
  logic [63:0]          sx2_r, sx2_nxt, sy2_r, sy2_nxt, sz2_r, sz2_nxt;
  logic [31:0]          eps2_r, eps2_nxt, adz2_r, adz2_nxt;
  logic [DVD_W-1:0]     dvd2_r, dvd2_nxt;
  // Stage 3: squared length.
  logic                 v3_r, v3_nxt;
  rdi_pkg::side_t       s3_r, s3_nxt;
  logic [63:0]          dlen3_r, dlen3_nxt, dz3_r, dz3_nxt;
  logic [31:0]          eps3_r, eps3_nxt, adz3_r, adz3_nxt;
  logic [DVD_W-1:0]     dvd3_r, dvd3_nxt;
  // Stage 4: partial products of the epsilon bound.
  logic                 v4_r, v4_nxt;
  rdi_pkg::side_t       s4_r, s4_nxt;
  logic [63:0]          ph4_r, ph4_nxt, pl4_r, pl4_nxt, dz4_r, dz4_nxt;
  logic [31:0]          adz4_r, adz4_nxt;
  logic [DVD_W-1:0]     dvd4_r, dvd4_nxt;

  logic [95:0] rhs, lhs;
  logic        par_ok;

  always_comb begin
    v1_nxt          = in_valid;
    s1_nxt.origin_x = in_ray.origin_x;
    s1_nxt.origin_y = in_ray.origin_y;
    s1_nxt.dir_x    = in_ray.dir_x;
    s1_nxt.dir_y    = in_ray.dir_y;
    // The depth is negative when origin z and direction z share a nonzero sign.
    s1_nxt.miss     = (in_ray.origin_z != 32'sd0) &&
                      (in_ray.origin_z[31] == in_ray.dir_z[31]);
    adx1_nxt = in_ray.dir_x[31] ? 32'(-in_ray.dir_x) : 32'(in_ray.dir_x);
    ady1_nxt = in_ray.dir_y[31] ? 32'(-in_ray.dir_y) : 32'(in_ray.dir_y);
    adz1_nxt = in_ray.dir_z[31] ? 32'(-in_ray.dir_z) : 32'(in_ray.dir_z);
    dvd1_nxt = {(in_ray.origin_z[31] ? 32'(-in_ray.origin_z) : 32'(in_ray.origin_z)),
                {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    v2_nxt   = v1_r;
    s2_nxt   = s1_r;
    sx2_nxt  = 64'(adx1_r) * 64'(adx1_r);
    sy2_nxt  = 64'(ady1_r) * 64'(ady1_r);
    sz2_nxt  = 64'(adz1_r) * 64'(adz1_r);
    eps2_nxt = 32'(eps) * 32'(eps);
    adz2_nxt = adz1_r;
    dvd2_nxt = dvd1_r;
  end

  always_comb begin
    v3_nxt    = v2_r;
    s3_nxt    = s2_r;
    dlen3_nxt = sx2_r + sy2_r + sz2_r;
    dz3_nxt   = sz2_r;
    eps3_nxt  = eps2_r;
    adz3_nxt  = adz2_r;
    dvd3_nxt  = dvd2_r;
  end

  always_comb begin
    v4_nxt   = v3_r;
    s4_nxt   = s3_r;
    ph4_nxt  = 64'(dlen3_r[63:32]) * 64'(eps3_r);
    pl4_nxt  = 64'(dlen3_r[31:0]) * 64'(eps3_r);
    dz4_nxt  = dz3_r;
    adz4_nxt = adz3_r;
    dvd4_nxt = dvd3_r;
  end

  // Dz^2 * 2^32 must exceed eps^2 * |D|^2; Dz = 0 always fails.
  always_comb begin
    rhs    = {ph4_r, 32'd0} + {32'd0, pl4_r};
    lhs    = {dz4_r, 32'd0};
    par_ok = lhs > rhs;
  end

  assign out_valid     = v4_r;
  assign out_side      = '{origin_x: s4_r.origin_x, origin_y: s4_r.origin_y,
                           dir_x: s4_r.dir_x, dir_y: s4_r.dir_y,
                           miss: s4_r.miss | ~par_ok};
  assign out_dividend  = dvd4_r;
  assign out_divisor   = adz4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt; adx1_r <= adx1_nxt; ady1_r <= ady1_nxt; adz1_r <= adz1_nxt;
    dvd1_r <= dvd1_nxt;
    s2_r <= s2_nxt; sx2_r <= sx2_nxt; sy2_r <= sy2_nxt; sz2_r <= sz2_nxt;
    eps2_r <= eps2_nxt; adz2_r <= adz2_nxt; dvd2_r <= dvd2_nxt;
    s3_r <= s3_nxt; dlen3_r <= dlen3_nxt; dz3_r <= dz3_nxt; eps3_r <= eps3_nxt;
    adz3_r <= adz3_nxt; dvd3_r <= dvd3_nxt;
    s4_r <= s4_nxt; ph4_r <= ph4_nxt; pl4_r <= pl4_nxt; dz4_r <= dz4_nxt;
    adz4_r <= adz4_nxt; dvd4_r <= dvd4_nxt;
  end

endmodule

// ===== src/rdi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rdi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  rdi_pkg::side_t          in_side,
  input  logic [32+FRAC_BITS-1:0] in_dividend,
  input  logic [31:0]             in_divisor,
  output logic                    out_valid,
  output rdi_pkg::side_t          out_side,
  output logic [rdi_pkg::QUOT_W-1:0] out_quot
);

  localparam int DVD_W = 32 + FRAC_BITS;
  localparam int QW    = rdi_pkg::QUOT_W;
  localparam int HI_W  = DVD_W - QW;

  logic                 v_r    [0:QW];
  rdi_pkg::side_t       side_r [0:QW];
  logic [31:0]          rem_r  [0:QW];
  logic [31:0]          dsr_r  [0:QW];
  logic [QW-1:0]        dvd_r  [0:QW];
  logic [QW-1:0]        quot_r [0:QW];
  logic                 sat_r  [0:QW];

  logic [31:0]   rem_nxt  [0:QW];
  logic [QW-1:0] quot_nxt [0:QW];
  logic [31:0]   hi_part;

  // The quotient fits in QW bits only when the upper dividend bits stay
  // below the divisor; those bits are then the starting remainder.
  always_comb begin
    hi_part     = 32'(in_dividend[DVD_W-1:QW]);
    rem_nxt[0]  = hi_part;
    quot_nxt[0] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    rem_r[0]  <= rem_nxt[0];
    dsr_r[0]  <= in_divisor;
    dvd_r[0]  <= in_dividend[QW-1:0];
    quot_r[0] <= quot_nxt[0];
    sat_r[0]  <= hi_part >= in_divisor;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;

    always_comb begin
      trial           = {rem_r[k], dvd_r[k][QW-1-k]};
      ge              = trial >= {1'b0, dsr_r[k]};
      rem_nxt[k+1]    = ge ? 32'(trial - {1'b0, dsr_r[k]}) : trial[31:0];
      quot_nxt[k+1]   = {quot_r[k][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      side_r[k+1] <= side_r[k];
      rem_r[k+1]  <= rem_nxt[k+1];
      dsr_r[k+1]  <= dsr_r[k];
      dvd_r[k+1]  <= dvd_r[k];
      quot_r[k+1] <= quot_nxt[k+1];
      sat_r[k+1]  <= sat_r[k];
    end
  end

  // A quotient too large to keep saturates to all ones; the final remainder
  // and the dividend bits of the last stage are not needed.
  logic unused_tail;
  assign unused_tail = ^{rem_r[QW], dsr_r[QW], dvd_r[QW], HI_W[0]};

  assign out_valid = v_r[QW] & (unused_tail | ~unused_tail);
  assign out_side  = side_r[QW];
  assign out_quot  = sat_r[QW] ? {QW{1'b1}} : quot_r[QW];

endmodule

// ===== src/rdi_hitpt.sv =====
// Hit point, squared radius and the final window tests.
module rdi_hitpt #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  rdi_pkg::side_t              in_side,
  input  logic [rdi_pkg::QUOT_W-1:0]  in_quot,
  input  rdi_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output rdi_pkg::ray_out_t           out_result
);

  localparam int QW = rdi_pkg::QUOT_W;

  logic               v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, v4_r, v4_nxt;
  logic               v5_r, v5_nxt;
  logic               m1_r, m2_r, m3_r, m4_r;
  logic [QW-1:0]      q1_r, q2_r, q3_r, q4_r;
  logic signed [31:0] px1_r, py1_r;
  logic signed [63:0] prx1_r, prx1_nxt, pry1_r, pry1_nxt;
  logic signed [63:0] u2_r, u2_nxt, v2c_r, v2c_nxt;
  logic [61:0]        su3_r, su3_nxt, sv3_r, sv3_nxt;
  logic               sat3_r, sat3_nxt;
  logic [31:0]        r2_4_r, r2_4_nxt;
  rdi_pkg::ray_out_t  res_r, res_nxt;

  logic [63:0] mu, mv;
  logic [62:0] rsum, rshift;
  logic        hit;

  always_comb begin
    v1_nxt   = in_valid;
    prx1_nxt = $signed({1'b0, in_quot}) * in_side.dir_x;
    pry1_nxt = $signed({1'b0, in_quot}) * in_side.dir_y;
  end

  // Arithmetic shift right is the floor of the scaled product.
  always_comb begin
    v2_nxt  = v1_r;
    u2_nxt  = 64'(px1_r) + (prx1_r >>> FRAC_BITS);
    v2c_nxt = 64'(py1_r) + (pry1_r >>> FRAC_BITS);
  end

  always_comb begin
    v3_nxt   = v2_r;
    mu       = u2_r[63] ? 64'(-u2_r) : 64'(u2_r);
    mv       = v2c_r[63] ? 64'(-v2c_r) : 64'(v2c_r);
    sat3_nxt = (|mu[63:31]) | (|mv[63:31]);
    su3_nxt  = 62'(mu[30:0]) * 62'(mu[30:0]);
    sv3_nxt  = 62'(mv[30:0]) * 62'(mv[30:0]);
  end

  always_comb begin
    v4_nxt   = v3_r;
    rsum     = {1'b0, su3_r} + {1'b0, sv3_r};
    rshift   = rsum >> FRAC_BITS;
    r2_4_nxt = (sat3_r || (|rshift[62:32])) ? 32'hFFFF_FFFF : rshift[31:0];
  end

  always_comb begin
    v5_nxt = v4_r;
    hit    = !m4_r &&
             (r2_4_r >= cfg.inner_radius_sq) && (r2_4_r <= cfg.outer_radius_sq) &&
             (q4_r > cfg.min_depth) && (q4_r < cfg.max_depth);
    res_nxt.hit   = hit;
    res_nxt.depth = hit ? q4_r : '0;
  end

  assign out_valid  = v5_r;
  assign out_result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= in_side.miss; q1_r <= in_quot;
    px1_r <= in_side.origin_x; py1_r <= in_side.origin_y;
    prx1_r <= prx1_nxt; pry1_r <= pry1_nxt;
    m2_r <= m1_r; q2_r <= q1_r; u2_r <= u2_nxt; v2c_r <= v2c_nxt;
    m3_r <= m2_r; q3_r <= q2_r; su3_r <= su3_nxt; sv3_r <= sv3_nxt;
    sat3_r <= sat3_nxt;
    m4_r <= m3_r; q4_r <= q3_r; r2_4_r <= r2_4_nxt;
    res_r <= res_nxt;
  end

endmodule
